// ===== sv/tagged_jpeg_frame_deframer_defines.svh =====
// Assertion macros for the tagged JPEG frame deframer
`ifndef TAGGED_JPEG_FRAME_DEFRAMER_DEFINES_SVH
`define TAGGED_JPEG_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TJD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TJD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tjd_pkg.sv =====
// Shared types and constants of the tagged JPEG frame deframer
package tjd_pkg;

    localparam int BUFFER_DEPTH_DEF = 65536;
    localparam int FRAME_DEPTH_DEF  = 32768;
    localparam int TRIM_KEEP_DEF    = 16;

    localparam int CAP_W            = 17;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

    localparam int QUEUE_DEPTH      = 2;
    localparam int HDR_BYTES        = 12;

    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CMD_FEED  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [7:0] MAGIC_J0 = 8'h4A;
    localparam logic [7:0] MAGIC_J1 = 8'h50;
    localparam logic [7:0] MAGIC_J2 = 8'h47;
    localparam logic [7:0] MAGIC_U0 = 8'h55;
    localparam logic [7:0] MAGIC_U1 = 8'h56;
    localparam logic [7:0] MAGIC_U2 = 8'h43;
    localparam logic [7:0] MAGIC_3  = 8'h30;

    localparam logic [15:0] HDR_MIN     = 16'd12;
    localparam logic [15:0] HDR_LIMIT   = 16'd65;
    localparam logic [31:0] PAYLOAD_MAX = 32'd32768;
    localparam int          UVC_EXTRA   = 8;

    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_D8 = 8'hD8;
    localparam logic [7:0] BYTE_D9 = 8'hD9;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic       end_of_chunk;
    } t_in_item;

    typedef struct packed {
        logic        frame_ready;
        logic [15:0] frame_tag;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       eoc;
    } t_cmd;

endpackage

// ===== sv/tjd_stream_if.sv =====
// Valid/ready channel carrying one item
interface tjd_stream_if #(parameter type t_payload = logic [0:0]) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/tjd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module tjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== sv/tjd_front.sv =====
// Front end: accepts items, decodes the operation, queues commands
module tjd_front import tjd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tjd_stream_if.sink       i_item,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_ready
);
    localparam int QA = $clog2(QUEUE_DEPTH);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [QA-1:0] r_wr;
    logic [QA-1:0] r_rd;
    logic [QA:0]   r_count;
    t_cmd          s_cmd;
    logic          s_push;
    logic          s_pop;

    always_comb begin
        s_cmd.data = i_item.payload.byte_value;
        s_cmd.eoc  = 1'b0;
        case (i_item.payload.operation)
            OP_FEED: begin
                s_cmd.kind = CMD_FEED;
                s_cmd.eoc  = i_item.payload.end_of_chunk;
            end
            OP_READ:  s_cmd.kind = CMD_READ;
            OP_CLEAR: s_cmd.kind = CMD_CLEAR;
            default:  s_cmd.kind = CMD_NOP;
        endcase
    end

    assign i_item.ready = (r_count != (QA+1)'(QUEUE_DEPTH));
    assign s_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_count != '0);
    assign o_cmd        = r_q[r_rd];
    assign s_pop        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (s_push) begin
                r_q[r_wr] <= s_cmd;
                r_wr      <= r_wr + 1'b1;
            end
            if (s_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_count <= r_count + 1'b1;
            end else if (s_pop && !s_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== sv/tjd_back.sv =====
// Back end: ring buffer, packet parser, frame store and result register
module tjd_back import tjd_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int FRAME_DEPTH  = FRAME_DEPTH_DEF,
    parameter int TRIM_KEEP    = TRIM_KEEP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_ready,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    tjd_stream_if.source     o_res
);
`include "tagged_jpeg_frame_deframer_defines.svh"

    localparam int BA = $clog2(BUFFER_DEPTH);
    localparam int FW = BA + 1;
    localparam int FA = $clog2(FRAME_DEPTH);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_PARSE  = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_LOADW  = 4'd4;
    localparam logic [3:0] S_EVAL   = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_SCANW  = 4'd7;
    localparam logic [3:0] S_COPY   = 4'd8;
    localparam logic [3:0] S_COPYW  = 4'd9;
    localparam logic [3:0] S_COMMIT = 4'd10;
    localparam logic [3:0] S_TRIM   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]       r_state;
    logic [BA-1:0]    r_start;
    logic [FW-1:0]    r_fill;
    logic [CAP_W-1:0] r_cap;
    logic             r_pending;
    logic [15:0]      r_tag;
    logic [15:0]      r_plen;
    logic [15:0]      r_rp;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic [3:0]       r_k;
    logic [3:0]       r_nload;
    logic [6:0]       r_hlen;
    logic [FW-1:0]    r_total;
    logic [FW-1:0]    r_j;
    logic [7:0]       r_next;
    logic             r_have_next;
    logic [15:0]      r_end;
    logic [15:0]      r_i;
    logic             r_ok0;
    logic             r_ok1;
    logic             r_trim;
    logic [7:0]       r_data;
    logic             r_last;
    logic             r_res_valid;
    t_out_item        r_res;

    logic [CW-1:0]    s_fill;
    logic [CW-1:0]    s_cap;
    logic             s_is_j;
    logic             s_is_u;
    logic [CW-1:0]    s_uvc_total;
    logic [15:0]      s_hlen;
    logic [31:0]      s_pay;
    logic             s_bad;
    logic [CW-1:0]    s_jtotal;
    logic [FW-1:0]    s_off;
    logic [FW-1:0]    s_copy_off;
    logic             s_we;
    logic [BA-1:0]    s_waddr;
    logic [BA-1:0]    s_raddr;
    logic [7:0]       s_rdata;
    logic             s_fwe;
    logic [7:0]       s_frdata;
    logic             s_slot_free;

    // ring index: start + offset, offset never beyond the depth
    function automatic logic [BA-1:0] f_wrap(input logic [BA-1:0] base,
                                             input logic [FW-1:0] off);
        logic [FW-1:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= FW'(BUFFER_DEPTH)) begin
            sum = sum - FW'(BUFFER_DEPTH);
        end
        return sum[BA-1:0];
    endfunction

    assign s_fill = CW'(r_fill);
    assign s_cap  = (CW'(r_cap) > CW'(BUFFER_DEPTH)) ? CW'(BUFFER_DEPTH) : CW'(r_cap);

    assign s_is_j = (r_hdr[0] == MAGIC_J0) && (r_hdr[1] == MAGIC_J1) &&
                    (r_hdr[2] == MAGIC_J2) && (r_hdr[3] == MAGIC_3);
    assign s_is_u = (r_hdr[0] == MAGIC_U0) && (r_hdr[1] == MAGIC_U1) &&
                    (r_hdr[2] == MAGIC_U2) && (r_hdr[3] == MAGIC_3);
    assign s_uvc_total = CW'(r_hdr[4]) + CW'(UVC_EXTRA);
    assign s_hlen = {r_hdr[7], r_hdr[6]};
    assign s_pay  = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign s_bad  = (s_hlen < HDR_MIN) || (s_hlen >= HDR_LIMIT) || (s_pay == '0) ||
                    (s_pay > PAYLOAD_MAX) || (s_pay > 32'(FRAME_DEPTH));
    assign s_jtotal = CW'(s_hlen[6:0]) + CW'(s_pay[15:0]);

    assign s_copy_off = FW'(CW'(r_hlen) + CW'(r_i));

    always_comb begin
        case (r_state)
            S_LOAD:  s_off = FW'(r_k);
            S_SCAN:  s_off = r_j;
            default: s_off = s_copy_off;
        endcase
    end

    assign s_raddr = f_wrap(r_start, s_off);
    assign s_waddr = f_wrap(r_start, r_fill);
    assign s_we    = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == CMD_FEED) &&
                     (s_fill < CW'(BUFFER_DEPTH));
    assign s_fwe   = (r_state == S_COPYW);

    tjd_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_stream_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    tjd_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (s_fwe),
        .i_waddr (FA'(r_i)),
        .i_wdata (s_rdata),
        .i_raddr (FA'(r_rp)),
        .o_rdata (s_frdata)
    );

    assign o_cmd_ready   = (r_state == S_IDLE);
    assign s_slot_free   = !r_res_valid || o_res.ready;
    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= '0;
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
            r_pending   <= 1'b0;
            r_tag       <= '0;
            r_plen      <= '0;
            r_rp        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && s_slot_free) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_data <= '0;
                        r_last <= 1'b0;
                        r_trim <= i_cmd.eoc;
                        case (i_cmd.kind)
                            CMD_FEED: begin
                                if (s_we) begin
                                    r_fill <= r_fill + 1'b1;
                                end
                                r_state <= S_PARSE;
                            end
                            CMD_READ: begin
                                r_state <= r_pending ? S_RDWAIT : S_DONE;
                            end
                            CMD_CLEAR: begin
                                r_start <= '0;
                                r_fill  <= '0;
                                r_state <= S_PARSE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_data <= s_frdata;
                    if ((r_rp + 16'd1) >= r_plen) begin
                        r_last    <= 1'b1;
                        r_pending <= 1'b0;
                        r_tag     <= '0;
                        r_plen    <= '0;
                        r_rp      <= '0;
                        r_state   <= S_PARSE;
                    end else begin
                        r_rp    <= r_rp + 16'd1;
                        r_state <= S_DONE;
                    end
                end
                S_PARSE: begin
                    if (r_pending || (s_fill < CW'(4))) begin
                        r_state <= S_TRIM;
                    end else begin
                        r_k     <= '0;
                        r_nload <= (s_fill >= CW'(HDR_BYTES)) ? 4'(HDR_BYTES) : r_fill[3:0];
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= S_LOADW;
                S_LOADW: begin
                    r_hdr[r_k] <= s_rdata;
                    r_k        <= r_k + 4'd1;
                    r_state    <= ((r_k + 4'd1) == r_nload) ? S_EVAL : S_LOAD;
                end
                S_EVAL: begin
                    if (!s_is_j && !s_is_u) begin
                        r_start <= f_wrap(r_start, FW'(1));
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_PARSE;
                    end else if (s_fill < CW'(8)) begin
                        r_state <= S_TRIM;
                    end else if (s_is_u) begin
                        if (s_uvc_total > s_cap) begin
                            r_start <= f_wrap(r_start, FW'(1));
                            r_fill  <= r_fill - 1'b1;
                            r_state <= S_PARSE;
                        end else if (s_fill < s_uvc_total) begin
                            r_state <= S_TRIM;
                        end else begin
                            r_start <= f_wrap(r_start, FW'(s_uvc_total));
                            r_fill  <= r_fill - FW'(s_uvc_total);
                            r_state <= S_PARSE;
                        end
                    end else if (s_fill < CW'(HDR_BYTES)) begin
                        r_state <= S_TRIM;
                    end else if (s_bad || (s_jtotal > s_cap)) begin
                        r_start <= f_wrap(r_start, FW'(1));
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_PARSE;
                    end else if (s_fill < s_jtotal) begin
                        r_state <= S_TRIM;
                    end else begin
                        r_hlen      <= s_hlen[6:0];
                        r_total     <= FW'(s_jtotal);
                        r_j         <= FW'(s_jtotal - CW'(1));
                        r_have_next <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: r_state <= S_SCANW;
                S_SCANW: begin
                    // backward search for the last FF D9 pair of the payload
                    if (r_have_next && (s_rdata == BYTE_FF) && (r_next == BYTE_D9)) begin
                        r_end   <= 16'(CW'(r_j) - CW'(r_hlen) + CW'(2));
                        r_i     <= '0;
                        r_state <= S_COPY;
                    end else if (r_j == FW'(r_hlen)) begin
                        r_start <= f_wrap(r_start, r_total);
                        r_fill  <= r_fill - r_total;
                        r_state <= S_PARSE;
                    end else begin
                        r_next      <= s_rdata;
                        r_have_next <= 1'b1;
                        r_j         <= r_j - 1'b1;
                        r_state     <= S_SCAN;
                    end
                end
                S_COPY: r_state <= S_COPYW;
                S_COPYW: begin
                    if (r_i == 16'd0) begin
                        r_ok0 <= (s_rdata == BYTE_FF);
                    end
                    if (r_i == 16'd1) begin
                        r_ok1 <= (s_rdata == BYTE_D8);
                    end
                    if ((r_i + 16'd1) == r_end) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_i     <= r_i + 16'd1;
                        r_state <= S_COPY;
                    end
                end
                S_COMMIT: begin
                    if (r_ok0 && r_ok1) begin
                        r_pending <= 1'b1;
                        r_tag     <= {r_hdr[5], r_hdr[4]};
                        r_plen    <= r_end;
                        r_rp      <= '0;
                    end
                    r_start <= f_wrap(r_start, r_total);
                    r_fill  <= r_fill - r_total;
                    r_state <= S_PARSE;
                end
                S_TRIM: begin
                    if (r_trim && (s_fill > s_cap) && (s_fill > CW'(TRIM_KEEP))) begin
                        r_start <= f_wrap(r_start, FW'(s_fill - CW'(TRIM_KEEP)));
                        r_fill  <= FW'(TRIM_KEEP);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (s_slot_free) begin
                        r_res.frame_ready  <= r_pending;
                        r_res.frame_tag    <= r_pending ? r_tag : '0;
                        r_res.frame_length <= r_pending ? r_plen : '0;
                        r_res.data_byte    <= r_data;
                        r_res.last_byte    <= r_last;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TJD_ASSERT_NOW(a_fill_bound, 1'b1, s_fill <= CW'(BUFFER_DEPTH), "fill beyond depth")
    `TJD_ASSERT_NOW(a_pending_len, r_pending, (r_plen != '0) && (r_rp < r_plen), "bad pending")
    `TJD_ASSERT_NEXT(a_cmd_taken, (r_state == S_IDLE) && i_cmd_valid, r_state != S_IDLE, "cmd lost")
    `TJD_ASSERT_NOW(a_parse_idle, r_pending, (r_state != S_SCANW) && (r_state != S_COPYW), "parse busy")
endmodule

// ===== sv/tagged_jpeg_frame_deframer.sv =====
// Top level of the tagged JPEG frame deframer
// Items enter on i_in_item (valid/ready): operation 0 feeds byte_value into the
// stream ring buffer (end_of_chunk marks a chunk end), 1 reads the next byte of
// the pending frame, 2 clears the stream buffer. Every item yields exactly one
// result on o_out_item: frame_ready, frame_tag, frame_length of the pending
// frame, and data_byte/last_byte for a read.
// The capacity register is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce it.
// Parsing runs in one shared sequencer over the stream RAM: a header look loads
// up to 12 header bytes and decodes them, the end marker search scans the
// payload backwards byte by byte, and each frame byte up to the marker is
// then copied into the frame RAM.
// A two-entry command queue in front keeps accepting until full while the sequencer
// works; a result register holds the result while the receiver stalls, and the
// sequencer waits for it before starting the next item.
// Reset (synchronous, active low) empties the buffer, drops any pending frame
// and sets the capacity to 65536. No clearing pass is needed.
module tagged_jpeg_frame_deframer import tjd_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int FRAME_DEPTH  = FRAME_DEPTH_DEF,
    parameter int TRIM_KEEP    = TRIM_KEEP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tjd_stream_if.sink       i_in_item,
    tjd_stream_if.source     o_out_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);
    logic s_cmd_valid;
    logic s_cmd_ready;
    t_cmd s_cmd;

    tjd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .o_cmd_valid (s_cmd_valid),
        .o_cmd       (s_cmd),
        .i_cmd_ready (s_cmd_ready)
    );

    tjd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .FRAME_DEPTH  (FRAME_DEPTH),
        .TRIM_KEEP    (TRIM_KEEP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_cmd_valid),
        .i_cmd       (s_cmd),
        .o_cmd_ready (s_cmd_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (o_out_item)
    );
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the tagged JPEG frame deframer: packet stream stimulus and scoreboard
module tb;
    import tjd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_MAX  = 65536;
    localparam int STORE_DEPTH = 32768;
    localparam int KEEP_TAIL   = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 800;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [1:0] op;
        logic [7:0] val;
        logic       eoc;
        bit         known;
        t_out_item  res;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CAP_W-1:0]     cfg_wdata;

    tjd_stream_if #(.t_payload(t_in_item))  in_if ();
    tjd_stream_if #(.t_payload(t_out_item)) out_if ();

    tagged_jpeg_frame_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (in_if.sink),
        .o_out_item  (out_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // deframer shadow state
    logic [7:0]   ring_q[$];
    logic [7:0]   frame_mem [0:STORE_DEPTH-1];
    int unsigned  cap_reg;
    bit           frm_pend;
    logic [15:0]  frm_tag;
    logic [15:0]  frm_len;
    int unsigned  frm_pos;

    t_out_item    expected_q[$];
    logic [7:0]   pkt_q[$];
    t_dir_row     dir_tab[$];

    t_idle_mode   idle_mode;
    int           hold_cycles;
    int           n_sent;
    int           n_results;
    int           n_frames;
    int           n_mismatch;
    longint       cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending", cycles,
                         expected_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int unsigned cap_limit();
        return (cap_reg > STREAM_MAX) ? STREAM_MAX : cap_reg;
    endfunction

    function automatic void drop_bytes(int unsigned n);
        repeat (n) if (ring_q.size() > 0) void'(ring_q.pop_front());
    endfunction

    function automatic bit magic_is(logic [7:0] m0, logic [7:0] m1, logic [7:0] m2);
        return ring_q[0] == m0 && ring_q[1] == m1 && ring_q[2] == m2 && ring_q[3] == MAGIC_3;
    endfunction

    function automatic void scan_stream();
        int unsigned lim, total, hdr, pay, eom;
        lim = cap_limit();
        while (!frm_pend) begin
            while (ring_q.size() >= 4 && !magic_is(MAGIC_J0, MAGIC_J1, MAGIC_J2) &&
                   !magic_is(MAGIC_U0, MAGIC_U1, MAGIC_U2))
                void'(ring_q.pop_front());
            if (ring_q.size() < 8) return;
            if (magic_is(MAGIC_U0, MAGIC_U1, MAGIC_U2)) begin
                total = ring_q[4] + UVC_EXTRA;
                if (total > lim) begin
                    drop_bytes(1);
                    continue;
                end
                if (ring_q.size() < total) return;
                drop_bytes(total);
                continue;
            end
            if (ring_q.size() < 12) return;
            hdr = {ring_q[7], ring_q[6]};
            pay = {ring_q[11], ring_q[10], ring_q[9], ring_q[8]};
            if (hdr < HDR_MIN || hdr >= HDR_LIMIT || pay == 0 || pay > PAYLOAD_MAX ||
                pay > STORE_DEPTH) begin
                drop_bytes(1);
                continue;
            end
            total = hdr + pay;
            if (total > lim) begin
                drop_bytes(1);
                continue;
            end
            if (ring_q.size() < total) return;
            eom = 0;
            for (int unsigned i = pay; i >= 2; i--) begin
                if (ring_q[hdr+i-2] == BYTE_FF && ring_q[hdr+i-1] == BYTE_D9) begin
                    eom = i;
                    break;
                end
            end
            if (eom >= 2 && ring_q[hdr] == BYTE_FF && ring_q[hdr+1] == BYTE_D8) begin
                for (int unsigned i = 0; i < eom; i++) frame_mem[i] = ring_q[hdr+i];
                frm_pend = 1'b1;
                frm_tag  = {ring_q[5], ring_q[4]};
                frm_len  = eom[15:0];
                frm_pos  = 0;
            end
            drop_bytes(total);
        end
    endfunction

    function automatic t_out_item deframe_step(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.operation)
            OP_FEED: begin
                if (ring_q.size() < STREAM_MAX) ring_q = {ring_q, it.byte_value};
                scan_stream();
                if (it.end_of_chunk && ring_q.size() > cap_limit() && ring_q.size() > KEEP_TAIL)
                    drop_bytes(ring_q.size() - KEEP_TAIL);
            end
            OP_READ: begin
                if (frm_pend) begin
                    r.data_byte = frame_mem[frm_pos % STORE_DEPTH];
                    frm_pos++;
                    if (frm_pos >= frm_len) begin
                        r.last_byte = 1'b1;
                        frm_pend = 1'b0;
                        frm_tag  = '0;
                        frm_len  = '0;
                        frm_pos  = 0;
                        n_frames++;
                        scan_stream();
                    end
                end
            end
            OP_CLEAR: begin
                ring_q.delete();
                scan_stream();
            end
            default: ;
        endcase
        r.frame_ready  = frm_pend;
        r.frame_tag    = frm_pend ? frm_tag : '0;
        r.frame_length = frm_pend ? frm_len : '0;
        return r;
    endfunction

    // called just after a rising edge; returns just after the edge that took the item
    task automatic send_item(t_in_item it, bit known = 0, t_out_item typed = '0);
        t_out_item p;
        int gap;
        bit rdy;
        p = deframe_step(it);
        expected_q = {expected_q, (known ? typed : p)};
        gap = 0;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
            while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 79 : 33) && gap < 40)
                gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do begin
            @(negedge i_clk);
            rdy = in_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        n_sent++;
    endtask

    task automatic send_op(logic [1:0] op, logic [7:0] val = '0, logic eoc = 1'b0);
        t_in_item it;
        it.operation    = op;
        it.byte_value   = val;
        it.end_of_chunk = eoc;
        send_item(it);
    endtask

    task automatic read_some(int pct);
        while (frm_pend && $urandom_range(99) < pct) send_op(OP_READ);
    endtask

    function automatic void put_le(int unsigned v, int nbytes);
        for (int i = 0; i < nbytes; i++) pkt_q = {pkt_q, 8'(v >> (8 * i))};
    endfunction

    // builds one packet, mostly well formed, into pkt_q
    function automatic void build_packet();
        int kind, hdr, body;
        logic [7:0] pay_q[$];
        pkt_q.delete();
        kind = $urandom_range(19);
        if (kind >= 17) begin
            repeat ($urandom_range(1, 10)) pkt_q = {pkt_q, 8'($urandom)};
            return;
        end
        if (kind >= 15) begin
            body = $urandom_range(40);
            pkt_q = '{MAGIC_U0, MAGIC_U1, MAGIC_U2, MAGIC_3, 8'(body)};
            repeat (body + 3) pkt_q = {pkt_q, 8'($urandom)};
            return;
        end
        if (kind == 12) begin
            repeat ($urandom_range(2, 20)) pay_q = {pay_q, 8'($urandom)};
        end else begin
            if (kind >= 10) pay_q = {pay_q, 8'($urandom)};
            else pay_q = {pay_q, BYTE_FF};
            pay_q = {pay_q, ((kind >= 10) ? 8'($urandom) : BYTE_D8)};
            repeat ($urandom_range(0, 30)) pay_q = {pay_q, 8'($urandom)};
            pay_q = {pay_q, BYTE_FF};
            pay_q = {pay_q, BYTE_D9};
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3))
                pay_q = {pay_q, 8'($urandom)};
        end
        hdr = ($urandom_range(7) == 0) ? 64 : $urandom_range(12, 20);
        if (kind == 13)
            hdr = ($urandom_range(1) == 0) ? $urandom_range(0, 11) : $urandom_range(65, 65535);
        pkt_q = '{MAGIC_J0, MAGIC_J1, MAGIC_J2, MAGIC_3};
        put_le($urandom, 2);
        put_le(hdr, 2);
        if (kind == 14)
            put_le(($urandom_range(1) == 0) ? 0 : $urandom_range(32769, 32'hFFFF_FFFF), 4);
        else
            put_le(pay_q.size(), 4);
        if (kind != 13) repeat (hdr - 12) pkt_q = {pkt_q, 8'($urandom)};
        foreach (pay_q[i]) pkt_q = {pkt_q, pay_q[i]};
    endfunction

    task automatic send_packet();
        build_packet();
        foreach (pkt_q[i]) begin
            read_some(75);
            send_op(OP_FEED, pkt_q[i], ($urandom_range(7) == 0) || i == pkt_q.size() - 1);
        end
        read_some(90);
        case ($urandom_range(59))
            0: send_op(OP_CLEAR, 8'($urandom), 1'($urandom));
            1: send_op(OP_UNKNOWN, 8'($urandom), 1'($urandom));
            2: send_op(OP_READ, 8'($urandom), 1'($urandom));
            default: ;
        endcase
    endtask

    task automatic settle_and_write(logic [CAP_W-1:0] v);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cap_reg = v;
    endtask

    task automatic add_row(logic [1:0] op, logic [7:0] val, logic eoc, bit known,
                           t_out_item res = '0);
        t_dir_row r;
        r.op = op;
        r.val = val;
        r.eoc = eoc;
        r.known = known;
        r.res = res;
        dir_tab = {dir_tab, r};
    endtask

    // result checker
    always @(negedge i_clk) begin
        t_out_item e, a;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            a = out_if.payload;
            n_results++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", a);
            end else begin
                e = expected_q.pop_front();
                if (a.frame_ready !== e.frame_ready || a.frame_tag !== e.frame_tag ||
                    a.frame_length !== e.frame_length || a.data_byte !== e.data_byte ||
                    a.last_byte !== e.last_byte) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d mismatch: expected %p got %p", n_results, e, a);
                end
            end
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            out_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_mode == IDLE_RECV) begin
            out_if.ready <= ($urandom_range(99) >= 79);
        end else if (idle_mode == IDLE_BOTH) begin
            out_if.ready <= ($urandom_range(99) >= 33);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    initial begin
        logic [CAP_W-1:0] caps[6];
        t_idle_mode modes[6];
        t_in_item it;
        caps  = '{CAP_RESET, 17'd16, 17'h1FFFF, 17'd0, 17'd48, CAP_RESET};
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        hold_cycles = 0;
        idle_mode = IDLE_NONE;
        n_sent = 0;
        n_results = 0;
        n_frames = 0;
        n_mismatch = 0;
        ring_q.delete();
        cap_reg = CAP_RESET;
        frm_pend = 1'b0;
        frm_tag = '0;
        frm_len = '0;
        frm_pos = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ops on an empty block, then one minimal frame read out
        add_row(OP_READ, 8'hFF, 1'b1, 1);
        add_row(OP_CLEAR, 8'h00, 1'b0, 1);
        add_row(OP_UNKNOWN, 8'hFF, 1'b1, 1);
        add_row(OP_FEED, 8'h00, 1'b0, 1);
        add_row(OP_FEED, 8'hFF, 1'b1, 1);
        add_row(OP_CLEAR, 8'hAA, 1'b1, 1);
        pkt_q = '{8'h4A, 8'h50, 8'h47, 8'h30, 8'h5A, 8'hA5, 8'h0C, 8'h00,
                  8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hD8, 8'hFF};
        foreach (pkt_q[i]) add_row(OP_FEED, pkt_q[i], 1'b0, 0);
        add_row(OP_FEED, 8'hD9, 1'b1, 1, '{1'b1, 16'hA55A, 16'd4, 8'h00, 1'b0});
        add_row(OP_READ, 8'h00, 1'b0, 1, '{1'b1, 16'hA55A, 16'd4, 8'hFF, 1'b0});
        add_row(OP_READ, 8'h00, 1'b0, 1, '{1'b1, 16'hA55A, 16'd4, 8'hD8, 1'b0});
        add_row(OP_READ, 8'h00, 1'b0, 1, '{1'b1, 16'hA55A, 16'd4, 8'hFF, 1'b0});
        add_row(OP_READ, 8'h00, 1'b0, 1, '{1'b0, 16'h0000, 16'd0, 8'hD9, 1'b1});
        foreach (dir_tab[i]) begin
            it.operation    = dir_tab[i].op;
            it.byte_value   = dir_tab[i].val;
            it.end_of_chunk = dir_tab[i].eoc;
            send_item(it, dir_tab[i].known, dir_tab[i].res);
        end

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) settle_and_write(caps[ph]);
            idle_mode = modes[ph];
            if (ph == 4) hold_cycles = 600;
            while (n_sent < 22 + 300 * (ph + 1)) send_packet();
            while (frm_pend) send_op(OP_READ);
        end
        in_if.valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("sent %0d items, checked %0d results, %0d frames read out, %0d mismatches",
                 n_sent, n_results, n_frames, n_mismatch);
        $display("capacities 16, 0, 48, 65536 and 131071; sender/receiver idling and a long stall");
        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== tagged_jpeg_frame_deframer.f =====
+incdir+sv
sv/tjd_pkg.sv
sv/tjd_stream_if.sv
sv/tjd_ram.sv
sv/tjd_front.sv
sv/tjd_back.sv
sv/tagged_jpeg_frame_deframer.sv
bench/tb.sv
